[sv/mvt_pkg.sv]
`timescale 1ns / 1ps

package mvt_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int ELEMS     = DIM * DIM;
   localparam int IDX_W     = $clog2(ELEMS);
   localparam int QDEPTH    = 4;
   localparam int PTR_W     = $clog2(QDEPTH);

   localparam logic signed [DATA_W-1:0] QMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] QMIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_XFORM = 1'b1
   } func_type;

   typedef struct packed {
      func_type                      func;
      logic [IDX_W-1:0]              index;
      logic [DATA_W-1:0]             value;
      logic [DIM-1:0][DATA_W-1:0]    vec;
   } cmd_type;

endpackage

[sv/mvt_front.sv]
`timescale 1ns / 1ps

module mvt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [3:0]                 req_elem_index,
   input  logic signed [31:0]         req_elem_value,
   input  logic signed [31:0]         req_vec_x,
   input  logic signed [31:0]         req_vec_y,
   input  logic signed [31:0]         req_vec_z,
   input  logic signed [31:0]         req_vec_w,
   input  logic                       q_pop,
   output logic                       q_valid,
   output mvt_pkg::cmd_type           q_cmd
);

   mvt_pkg::cmd_type                  slot_ff [mvt_pkg::QDEPTH];
   mvt_pkg::cmd_type                  cmd_in;
   logic [mvt_pkg::PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mvt_pkg::PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mvt_pkg::PTR_W:0]           count_ff, count_in;
   logic                              push;

   // classify the incoming transfer
   always_comb begin
      cmd_in.func  = mvt_pkg::func_type'(req_func);
      cmd_in.index = req_elem_index;
      cmd_in.value = req_elem_value;
      cmd_in.vec   = {req_vec_w, req_vec_z, req_vec_y, req_vec_x};
   end

   assign req_stall = (count_ff == (mvt_pkg::PTR_W+1)'(mvt_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (mvt_pkg::PTR_W+1)'(mvt_pkg::QDEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

[sv/mvt_back.sv]
`timescale 1ns / 1ps

module mvt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  mvt_pkg::cmd_type           q_cmd,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [31:0]         rsp_out_x,
   output logic signed [31:0]         rsp_out_y,
   output logic signed [31:0]         rsp_out_z,
   output logic signed [31:0]         rsp_out_w,
   output logic                       rsp_overflow
);

   logic signed [mvt_pkg::DATA_W-1:0] matrix_ff [mvt_pkg::ELEMS];
   logic signed [mvt_pkg::PROD_W-1:0] prod_ff   [mvt_pkg::DIM][mvt_pkg::DIM];
   logic signed [mvt_pkg::PROD_W-1:0] prod_in   [mvt_pkg::DIM][mvt_pkg::DIM];
   logic signed [mvt_pkg::PAIR_W-1:0] pair_ff   [mvt_pkg::DIM][2];
   logic signed [mvt_pkg::PAIR_W-1:0] pair_in   [mvt_pkg::DIM][2];
   logic signed [mvt_pkg::DATA_W-1:0] rsp_data_ff [mvt_pkg::DIM];
   logic signed [mvt_pkg::DATA_W-1:0] rsp_data_in [mvt_pkg::DIM];
   logic                              rsp_ovf_ff, rsp_ovf_in;
   logic                              p1_valid_ff, p2_valid_ff, rsp_valid_ff;
   logic                              out_take, p2_take, p1_take;
   logic                              is_load, load_pop, xform_pop;

   assign out_take  = !rsp_valid_ff || !rsp_stall;
   assign p2_take   = !p2_valid_ff || out_take;
   assign p1_take   = !p1_valid_ff || p2_take;
   assign is_load   = (q_cmd.func == mvt_pkg::FUNC_LOAD);
   assign q_pop     = q_valid && (is_load || p1_take);
   assign load_pop  = q_pop && is_load;
   assign xform_pop = q_pop && !is_load;

   // products against the matrix as it stands at pop time
   always_comb begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
         for (int j = 0; j < mvt_pkg::DIM; j++) begin
            prod_in[i][j] = mvt_pkg::PROD_W'(matrix_ff[i*mvt_pkg::DIM+j])
                          * mvt_pkg::PROD_W'($signed(q_cmd.vec[j]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
         pair_in[i][0] = mvt_pkg::PAIR_W'(prod_ff[i][0]) + mvt_pkg::PAIR_W'(prod_ff[i][1]);
         pair_in[i][1] = mvt_pkg::PAIR_W'(prod_ff[i][2]) + mvt_pkg::PAIR_W'(prod_ff[i][3]);
      end
   end

   // final add, floor shift, saturate
   always_comb begin
      logic signed [mvt_pkg::SUM_W-1:0] sum;
      logic signed [mvt_pkg::SUM_W-1:0] shifted;
      rsp_ovf_in = 1'b0;
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
         sum     = mvt_pkg::SUM_W'(pair_ff[i][0]) + mvt_pkg::SUM_W'(pair_ff[i][1]);
         shifted = sum >>> mvt_pkg::FRAC_BITS;
         if (shifted > mvt_pkg::SUM_W'(mvt_pkg::QMAX)) begin
            rsp_data_in[i] = mvt_pkg::QMAX;
            rsp_ovf_in     = 1'b1;
         end else if (shifted < mvt_pkg::SUM_W'(mvt_pkg::QMIN)) begin
            rsp_data_in[i] = mvt_pkg::QMIN;
            rsp_ovf_in     = 1'b1;
         end else begin
            rsp_data_in[i] = shifted[mvt_pkg::DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mvt_pkg::ELEMS; k++) begin
            matrix_ff[k] <= '0;
         end
      end else if (load_pop) begin
         matrix_ff[q_cmd.index] <= $signed(q_cmd.value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (p1_take) begin
            p1_valid_ff <= xform_pop;
         end
         if (p2_take) begin
            p2_valid_ff <= p1_valid_ff;
         end
         if (out_take) begin
            rsp_valid_ff <= p2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (xform_pop) begin
         prod_ff <= prod_in;
      end
      if (p2_take && p1_valid_ff) begin
         pair_ff <= pair_in;
      end
      if (out_take && p2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ovf_ff  <= rsp_ovf_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_data_ff[0];
   assign rsp_out_y    = rsp_data_ff[1];
   assign rsp_out_z    = rsp_data_ff[2];
   assign rsp_out_w    = rsp_data_ff[3];
   assign rsp_overflow = rsp_ovf_ff;

   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      xform_pop |=> p1_valid_ff)
      else $error("popped transform lost before product stage");

   a_p2_hold: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && !out_take |=> p2_valid_ff)
      else $error("sum stage dropped a held item");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |->
         (rsp_data_ff[0] == mvt_pkg::QMAX || rsp_data_ff[0] == mvt_pkg::QMIN ||
          rsp_data_ff[1] == mvt_pkg::QMAX || rsp_data_ff[1] == mvt_pkg::QMIN ||
          rsp_data_ff[2] == mvt_pkg::QMAX || rsp_data_ff[2] == mvt_pkg::QMIN ||
          rsp_data_ff[3] == mvt_pkg::QMAX || rsp_data_ff[3] == mvt_pkg::QMIN))
      else $error("overflow flag without a saturated component");

endmodule

[sv/matrix_vector_transform_4x4.sv]
`timescale 1ns / 1ps
// channel   ports                              transfer when
// req       req_valid, req_stall, req_*        req_valid && !req_stall
// rsp       rsp_valid, rsp_stall, rsp_*        rsp_valid && !rsp_stall
//
// One item per cycle is taken while req_stall is low; loads give no response,
// transforms give one. A transform's response passes the queue slot written at the
// transfer, then product stage (16 multipliers), pair-sum stage, final sum with
// saturation.
// Reset clears the matrix to zero, the four-entry queue and all stage valids.
// A stalled response holds the stages behind it; req_stall rises when the queue is full.

module matrix_vector_transform_4x4 (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [3:0]          req_elem_index,
   input  logic signed [31:0]  req_elem_value,
   input  logic signed [31:0]  req_vec_x,
   input  logic signed [31:0]  req_vec_y,
   input  logic signed [31:0]  req_vec_z,
   input  logic signed [31:0]  req_vec_w,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic signed [31:0]  rsp_out_w,
   output logic                rsp_overflow
);

   logic              q_valid;
   logic              q_pop;
   mvt_pkg::cmd_type  q_cmd;

   mvt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_vec_z      (req_vec_z),
      .req_vec_w      (req_vec_w),
      .q_pop          (q_pop),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd)
   );

   mvt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOW_LIMIT  = 40;

   localparam logic signed [67:0] SUM_HI = 68'sd2147483647;
   localparam logic signed [67:0] SUM_LO = -68'sd2147483648;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      logic        ovf;
   } xform_result_type;

   typedef struct packed {
      mvt_pkg::func_type func;
      logic [3:0]        idx;
      logic [31:0]       val;
      logic [3:0][31:0]  vec;
      logic              typed;
      xform_result_type  want;
   } vertex_cmd_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func = 1'b0;
   logic [3:0]         req_elem_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_vec_z = '0;
   logic signed [31:0] req_vec_w = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic signed [31:0] rsp_out_w;
   logic               rsp_overflow;

   logic signed [31:0] coeff [16];
   xform_result_type   pending_results [$];
   vertex_cmd_type     directed_cmds [$];
   vertex_cmd_type     cur_cmd;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int sent_count    = 0;
   int load_count    = 0;
   int xform_count   = 0;
   int result_count  = 0;
   int sat_count     = 0;
   int errors        = 0;

   matrix_vector_transform_4x4 u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_vec_z      (req_vec_z),
      .req_vec_w      (req_vec_w),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_w      (rsp_out_w),
      .rsp_overflow   (rsp_overflow)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // exact dot product, floor shift, saturate each row
   function automatic xform_result_type transform_vector(input logic [3:0][31:0] v);
      xform_result_type   r;
      logic signed [67:0] acc;
      logic signed [67:0] q;
      logic [3:0][31:0]   row_out;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         acc = '0;
         for (int j = 0; j < 4; j++)
            acc = acc + $signed(coeff[i*4+j]) * $signed(v[j]);
         q = acc >>> mvt_pkg::FRAC_BITS;
         if (q > SUM_HI) begin
            row_out[i] = mvt_pkg::QMAX;
            r.ovf = 1'b1;
         end else if (q < SUM_LO) begin
            row_out[i] = mvt_pkg::QMIN;
            r.ovf = 1'b1;
         end else begin
            row_out[i] = q[31:0];
         end
      end
      r.x = row_out[0];
      r.y = row_out[1];
      r.z = row_out[2];
      r.w = row_out[3];
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v = mvt_pkg::QMAX;
         1: v = mvt_pkg::QMIN;
         2: v = {32{v[0]}};
         3: v = v[0] ? 32'h0001_0000 : 32'hFFFF_0000;
         4, 5, 6: v = {{13{v[19]}}, v[18:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= SHOW_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      xform_result_type want;
      xform_result_type got;
      logic [3:0][31:0] v;
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_overflow};
            result_count++;
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= SHOW_LIMIT)
                  $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = pending_results.pop_front();
               check_field("out_x", want.x, got.x);
               check_field("out_y", want.y, got.y);
               check_field("out_z", want.z, got.z);
               check_field("out_w", want.w, got.w);
               check_field("overflow", 32'(want.ovf), 32'(got.ovf));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == mvt_pkg::FUNC_LOAD) begin
               load_count++;
               coeff[req_elem_index] = req_elem_value;
            end else begin
               xform_count++;
               v = {req_vec_w, req_vec_z, req_vec_y, req_vec_x};
               want = cur_cmd.typed ? cur_cmd.want : transform_vector(v);
               if (want.ovf)
                  sat_count++;
               pending_results.push_back(want);
            end
         end
      end
   end

   task automatic send_item(input vertex_cmd_type c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_cmd = c;
      req_valid      <= 1'b1;
      req_func       <= c.func;
      req_elem_index <= c.idx;
      req_elem_value <= c.val;
      req_vec_x      <= c.vec[0];
      req_vec_y      <= c.vec[1];
      req_vec_z      <= c.vec[2];
      req_vec_w      <= c.vec[3];
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // hold off the sender until every transform has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic add_row(input mvt_pkg::func_type f, input logic [3:0] idx,
                          input logic [31:0] val,
                          input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] vz, input logic [31:0] vw,
                          input logic typed, input xform_result_type want);
      vertex_cmd_type c;
      c.func  = f;
      c.idx   = idx;
      c.val   = val;
      c.vec   = {vw, vz, vy, vx};
      c.typed = typed;
      c.want  = want;
      directed_cmds.push_back(c);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      vertex_cmd_type c;
      int             nload;
      int             nxf;
      int             target;
      for (int k = 0; k < 16; k++)
         coeff[k] = '0;

      add_row(mvt_pkg::FUNC_XFORM, 4'hF, mvt_pkg::QMAX, mvt_pkg::QMAX, mvt_pkg::QMIN,
              32'h1, 32'hFFFF_FFFF, 1'b1, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd0, 32'h0001_0000, mvt_pkg::QMIN, mvt_pkg::QMAX,
              $urandom, $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd5, 32'h0001_0000, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd10, 32'h0001_0000, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd15, 32'h0001_0000, mvt_pkg::QMAX, mvt_pkg::QMAX,
              mvt_pkg::QMAX, mvt_pkg::QMAX, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, mvt_pkg::QMIN, mvt_pkg::QMAX, mvt_pkg::QMIN,
              32'h0, 32'hFFFF_FFFF, 1'b1,
              '{mvt_pkg::QMAX, mvt_pkg::QMIN, 32'h0, 32'hFFFF_FFFF, 1'b0});
      add_row(mvt_pkg::FUNC_XFORM, 4'd7, 32'h0, 32'h0001_8000, 32'hFFFF_8000, 32'h1,
              32'h0, 1'b1, '{32'h0001_8000, 32'hFFFF_8000, 32'h1, 32'h0, 1'b0});
      add_row(mvt_pkg::FUNC_XFORM, 4'd3, 32'h1234, 32'h0002_0000, 32'h0003_0000,
              32'hFFFC_0000, 32'h0001_0000, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd1, mvt_pkg::QMAX, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd2, mvt_pkg::QMAX, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, 32'h0, mvt_pkg::QMAX, mvt_pkg::QMAX,
              mvt_pkg::QMAX, 32'h0, 1'b1,
              '{mvt_pkg::QMAX, mvt_pkg::QMAX, mvt_pkg::QMAX, 32'h0, 1'b1});
      add_row(mvt_pkg::FUNC_LOAD, 4'd4, mvt_pkg::QMIN, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd9, mvt_pkg::QMAX, mvt_pkg::QMAX, mvt_pkg::QMAX,
              32'h0, 32'h0, 1'b1, '{mvt_pkg::QMAX, mvt_pkg::QMIN, 32'h0, 32'h0, 1'b1});
      add_row(mvt_pkg::FUNC_LOAD, 4'd12, 32'hFFFF_FFFF, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd15, mvt_pkg::QMIN, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, mvt_pkg::QMIN,
              1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, 32'h0, mvt_pkg::QMIN, mvt_pkg::QMIN,
              mvt_pkg::QMIN, mvt_pkg::QMIN, 1'b0, '0);
      add_row(mvt_pkg::FUNC_LOAD, 4'd1, 32'hFFFF_8000, $urandom, $urandom, $urandom,
              $urandom, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, 32'h0, 32'h0000_4000, 32'h0000_0001,
              32'hFFFF_FFFF, 32'h0001_0000, 1'b0, '0);
      add_row(mvt_pkg::FUNC_XFORM, 4'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);

      send_idle_pct = 35;
      recv_idle_pct = 83;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_cmds[k])
         send_item(directed_cmds[k]);
      drain_results();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 83 : 0;
         recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 35 : 0;
         target = sent_count + 410;
         while (sent_count < target) begin
            if ($urandom_range(0, 99) < 75) begin
               nload = $urandom_range(0, 16);
               for (int k = 0; k < nload; k++) begin
                  c.func  = mvt_pkg::FUNC_LOAD;
                  c.idx   = (nload == 16) ? k[3:0] : 4'($urandom_range(0, 15));
                  c.val   = rand_value();
                  c.vec   = {$urandom, $urandom, $urandom, $urandom};
                  c.typed = 1'b0;
                  c.want  = '0;
                  send_item(c);
               end
               nxf = $urandom_range(1, 4);
               for (int k = 0; k < nxf; k++) begin
                  c.func  = mvt_pkg::FUNC_XFORM;
                  c.idx   = 4'($urandom);
                  c.val   = $urandom;
                  c.typed = 1'b0;
                  c.want  = '0;
                  for (int j = 0; j < 4; j++)
                     c.vec[j] = rand_value();
                  if ($urandom_range(0, 99) < 30)
                     c.vec[3] = 32'h0001_0000;
                  send_item(c);
               end
            end else begin
               c.func  = mvt_pkg::func_type'($urandom_range(0, 1));
               c.idx   = 4'($urandom);
               c.val   = $urandom;
               c.vec   = {$urandom, $urandom, $urandom, $urandom};
               c.typed = 1'b0;
               c.want  = '0;
               send_item(c);
            end
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors += pending_results.size();
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      end

      $display("Covered %0d transfers in (%0d loads, %0d transforms) and %0d results,",
               sent_count, load_count, xform_count, result_count);
      $display("%0d of them saturated, under sender/receiver idling 35/83, 83/35 and none.",
               sat_count);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
